[hdl/sdev_pkg.sv]
// ----------------------------------------------------------------------------
// sdev_pkg
// Shared types and fixed widths for the series mean and deviation block:
// port widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package sdev_pkg;

   // fixed port widths
   localparam int SAMPLE_W = 16;
   localparam int SKIP_W   = 12;
   localparam int MEAN_W   = 24;
   localparam int MSQ_W    = 40;
   localparam int SIGMA_W  = 23;
   localparam int COUNT_W  = 13;

   // saturating position inside a series
   localparam int                 POS_W   = 13;
   localparam logic [POS_W-1:0]   POS_MAX = '1;

   // fraction bits of the results and scale of the variance before the root
   localparam int Q_BITS     = 8;
   localparam int SCALE_BITS = 16;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_MEAN,
      ST_LOAD_MSQ,
      ST_DIV_MSQ,
      ST_LOAD_MUL1,
      ST_MUL1,
      ST_LOAD_MUL2,
      ST_MUL2,
      ST_LOAD_SQRT,
      ST_SQRT,
      ST_LOAD_SIG,
      ST_DIV_SIG,
      ST_FINISH
   } sdev_state_type;

   // dividend choice for the shared divider
   typedef enum logic [1:0] {
      DIV_SEL_MEAN,
      DIV_SEL_MSQ,
      DIV_SEL_SIGMA
   } sdev_div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic             accum;
      logic             div_load;
      sdev_div_sel_type div_sel;
      logic             div_step;
      logic             save_mean;
      logic             save_msq;
      logic             mul_load;
      logic             mul_sub;
      logic             mul_step;
      logic             sqrt_load;
      logic             sqrt_step;
      logic             out_load;
   } sdev_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
   } sdev_status_type;

endpackage

[hdl/series_mean_and_deviation_top.sv]
// ----------------------------------------------------------------------------
// series_mean_and_deviation_top
// Mean, mean square and standard deviation of a sample series in Q.8.
// ----------------------------------------------------------------------------
// Samples are taken while the block is idle, so a series streams at one
// sample per clock. The last sample is also taken, and then the input stalls
// while the result is worked out by a single bit-serial divider (used for
// mean, mean square and sigma), a shift-add multiplier (two passes, n*S2
// then S1*S1) and a digit-by-digit square root; these steps are skipped when
// every sample of the series was skipped. The result sits in an output
// register, so it may wait on rsp_stall while the next series is streaming
// in; a second result waits until the first is taken. skip_count is written
// through csr_wr_en/csr_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce.
module series_mean_and_deviation_top #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sdev_pkg::SKIP_W-1:0]     csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sdev_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sdev_pkg::MEAN_W-1:0]     rsp_mean_q8,
   output logic [sdev_pkg::MSQ_W-1:0]      rsp_mean_sq_q8,
   output logic [sdev_pkg::SIGMA_W-1:0]    rsp_sigma_q8,
   output logic [sdev_pkg::COUNT_W-1:0]    rsp_used_count,
   output logic                            rsp_empty_res,
   output logic                            rsp_overflow
);
   import sdev_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
   localparam int PROD_W = CNT_W + SQ_W;
   localparam int ROOT_W = (PROD_W + SCALE_BITS + 1) / 2;
   localparam int DIV_W  = (SQ_W + Q_BITS > ROOT_W) ? (SQ_W + Q_BITS) : ROOT_W;

   sdev_cmd_type    cmd;
   sdev_status_type status;

   sdev_ctrl #(
      .DIV_STEPS  (DIV_W),
      .MUL_STEPS  (SUM_W),
      .SQRT_STEPS (ROOT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   sdev_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SQ_W        (SQ_W),
      .PROD_W      (PROD_W),
      .ROOT_W      (ROOT_W),
      .DIV_W       (DIV_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_sample     (req_sample),
      .rsp_mean_q8    (rsp_mean_q8),
      .rsp_mean_sq_q8 (rsp_mean_sq_q8),
      .rsp_sigma_q8   (rsp_sigma_q8),
      .rsp_used_count (rsp_used_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_overflow   (rsp_overflow)
   );

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over a waiting transaction");

   // samples are accumulated only on an accepted transaction
   a_accum_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accum |-> (req_valid && !req_stall))
      else $error("accumulate without an accepted transaction");

   // the block goes busy right after the last sample of a series
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> req_stall)
      else $error("input not stalled after last sample");

   // an empty result carries zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |->
         (rsp_mean_q8 == '0 && rsp_sigma_q8 == '0 && rsp_overflow == 1'b0))
      else $error("empty result with nonzero fields");

endmodule

[hdl/sdev_ctrl.sv]
// ----------------------------------------------------------------------------
// sdev_ctrl
// Controller: takes samples while idle, then sequences the finishing steps
// (two divides, a two-pass multiply, a square root, a divide), skipped for an
// empty series, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sdev_ctrl #(
   parameter int DIV_STEPS  = 53,
   parameter int MUL_STEPS  = 29,
   parameter int SQRT_STEPS = 44
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sdev_pkg::sdev_cmd_type    cmd,
   input  sdev_pkg::sdev_status_type status
);
   import sdev_pkg::*;

   localparam int MAX_STEPS = (DIV_STEPS > MUL_STEPS) ?
                              ((DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS) :
                              ((MUL_STEPS > SQRT_STEPS) ? MUL_STEPS : SQRT_STEPS);
   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   sdev_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              step_done;

   // state, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_done = (step_ff == STEP_W'(1));
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.div_sel  = DIV_SEL_MEAN;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last) state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_load = 1'b1;
               cmd.div_sel  = DIV_SEL_MEAN;
               step_in      = STEP_W'(DIV_STEPS);
               state_in     = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) state_in = ST_LOAD_MSQ;
         end
         ST_LOAD_MSQ: begin
            cmd.save_mean = 1'b1;
            cmd.div_load  = 1'b1;
            cmd.div_sel   = DIV_SEL_MSQ;
            step_in       = STEP_W'(DIV_STEPS);
            state_in      = ST_DIV_MSQ;
         end
         ST_DIV_MSQ: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) state_in = ST_LOAD_MUL1;
         end
         ST_LOAD_MUL1: begin
            cmd.save_msq = 1'b1;
            cmd.mul_load = 1'b1;
            step_in      = STEP_W'(MUL_STEPS);
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) state_in = ST_LOAD_MUL2;
         end
         ST_LOAD_MUL2: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sub  = 1'b1;
            step_in      = STEP_W'(MUL_STEPS);
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) state_in = ST_LOAD_SQRT;
         end
         ST_LOAD_SQRT: begin
            cmd.sqrt_load = 1'b1;
            step_in       = STEP_W'(SQRT_STEPS);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff - 1'b1;
            if (step_done) state_in = ST_LOAD_SIG;
         end
         ST_LOAD_SIG: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_SEL_SIGMA;
            step_in      = STEP_W'(DIV_STEPS);
            state_in     = ST_DIV_SIG;
         end
         ST_DIV_SIG: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/sdev_datapath.sv]
// ----------------------------------------------------------------------------
// sdev_datapath
// Datapath: skip register, series accumulators, a bit-serial restoring
// divider, a shift-add multiplier for n*S2 - S1*S1, a digit-by-digit square
// root and the result register.
// ----------------------------------------------------------------------------
module sdev_datapath #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 13,
   parameter int SUM_W       = 29,
   parameter int SQ_W        = 45,
   parameter int PROD_W      = 58,
   parameter int ROOT_W      = 37,
   parameter int DIV_W       = 53
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sdev_pkg::sdev_cmd_type           cmd,
   output sdev_pkg::sdev_status_type        status,
   input  logic                            csr_wr_en,
   input  logic [sdev_pkg::SKIP_W-1:0]     csr_wr_data,
   input  logic [sdev_pkg::SAMPLE_W-1:0]   req_sample,
   output logic [sdev_pkg::MEAN_W-1:0]     rsp_mean_q8,
   output logic [sdev_pkg::MSQ_W-1:0]      rsp_mean_sq_q8,
   output logic [sdev_pkg::SIGMA_W-1:0]    rsp_sigma_q8,
   output logic [sdev_pkg::COUNT_W-1:0]    rsp_used_count,
   output logic                            rsp_empty_res,
   output logic                            rsp_overflow
);
   import sdev_pkg::*;

   // configuration and series state
   logic [SKIP_W-1:0]      skip_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   drop_ff, drop_in;

   // finishing units
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [PROD_W-1:0]      mcand_ff, mcand_in;
   logic [SUM_W-1:0]       mplier_ff, mplier_in;
   logic                   sub_ff, sub_in;
   logic [2*ROOT_W-1:0]    op_ff, op_in;
   logic [ROOT_W+1:0]      srem_ff, srem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [MEAN_W-1:0]      mean_ff;
   logic [MSQ_W-1:0]       msq_ff;

   logic [SAMPLE_BITS-1:0]   x;
   logic [2*SAMPLE_BITS-1:0] x_sq;
   logic                     in_use;
   logic [CNT_W:0]           rem_sh;
   logic                     rem_ge;
   logic [ROOT_W+3:0]        srem_sh;
   logic [ROOT_W+3:0]        trial;

   assign status.empty = (used_ff == '0);

   // sample to its used bits and its square
   assign x      = SAMPLE_BITS'(req_sample);
   assign x_sq   = {{SAMPLE_BITS{1'b0}}, x} * {{SAMPLE_BITS{1'b0}}, x};
   assign in_use = (pos_ff >= {{(POS_W-SKIP_W){1'b0}}, skip_ff});

   // accumulate one transaction, clear when the result is loaded into the result register
   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      used_in = used_ff;
      drop_in = drop_ff;
      if (cmd.out_load) begin
         pos_in  = '0;
         sum_in  = '0;
         sq_in   = '0;
         used_in = '0;
         drop_in = 1'b0;
      end else if (cmd.accum) begin
         if (in_use) begin
            if (used_ff < CNT_W'(MAX_SAMPLES)) begin
               sum_in  = sum_ff + SUM_W'(x);
               sq_in   = sq_ff + SQ_W'(x_sq);
               used_in = used_ff + 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end
         if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         pos_ff  <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         used_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         if (csr_wr_en) skip_ff <= csr_wr_data;
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         used_ff <= used_in;
         drop_ff <= drop_in;
      end
   end

   // restoring divider by the used count, one quotient bit per step
   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, used_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         unique case (cmd.div_sel)
            DIV_SEL_MEAN:  quo_in = DIV_W'({sum_ff, {Q_BITS{1'b0}}});
            DIV_SEL_MSQ:   quo_in = DIV_W'({sq_ff, {Q_BITS{1'b0}}});
            DIV_SEL_SIGMA: quo_in = DIV_W'(root_ff);
            default:       quo_in = '0;
         endcase
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? CNT_W'(rem_sh - {1'b0, used_ff}) : CNT_W'(rem_sh);
         quo_in = {quo_ff[DIV_W-2:0], rem_ge};
      end
   end

   // shift-add multiply: pass one adds n*S2, pass two takes off S1*S1
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      sub_in    = sub_ff;
      if (cmd.mul_load) begin
         sub_in = cmd.mul_sub;
         if (cmd.mul_sub) begin
            mcand_in  = PROD_W'(sum_ff);
            mplier_in = sum_ff;
         end else begin
            acc_in    = '0;
            mcand_in  = PROD_W'(sq_ff);
            mplier_in = SUM_W'(used_ff);
         end
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) acc_in = sub_ff ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[SUM_W-1:1]};
      end
   end

   // square root of the scaled variance, two operand bits per step
   assign srem_sh = {srem_ff, op_ff[2*ROOT_W-1 -: 2]};
   assign trial   = (ROOT_W+4)'({root_ff, 2'b01});

   always_comb begin
      op_in   = op_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sqrt_load) begin
         op_in   = (2*ROOT_W)'({acc_ff, {SCALE_BITS{1'b0}}});
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         op_in = {op_ff[2*ROOT_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_in = (ROOT_W+2)'(srem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_in = (ROOT_W+2)'(srem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // finishing registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      sub_ff    <= sub_in;
      op_ff     <= op_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      if (cmd.save_mean) mean_ff <= MEAN_W'(quo_ff);
      if (cmd.save_msq)  msq_ff  <= MSQ_W'(quo_ff);
   end

   // result register, zeros for an empty series
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (status.empty) begin
            rsp_mean_q8    <= '0;
            rsp_mean_sq_q8 <= '0;
            rsp_sigma_q8   <= '0;
            rsp_used_count <= '0;
            rsp_empty_res  <= 1'b1;
            rsp_overflow   <= 1'b0;
         end else begin
            rsp_mean_q8    <= mean_ff;
            rsp_mean_sq_q8 <= msq_ff;
            rsp_sigma_q8   <= SIGMA_W'(quo_ff);
            rsp_used_count <= COUNT_W'(used_ff);
            rsp_empty_res  <= 1'b0;
            rsp_overflow   <= drop_ff;
         end
      end
   end

endmodule
